@@ src/rscf_pkg.sv @@
// Constants, register map and CRC-32 byte update for the report sequence/CRC framer.
package rscf_pkg;

   localparam int unsigned MAX_REPORT_BYTES = 256;

   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES     = 32'hFFFF_FFFF;
   localparam logic [7:0]  PREFIX_RESET = 8'hA2;
   localparam logic [7:0]  OFFSET_RESET = 8'h00;

   localparam int unsigned CSR_ADDR_W = 3;

   // Register index, taken from paddr[2]
   localparam logic REG_SEQ_OFFSET = 1'b0;
   localparam logic REG_CRC_PREFIX = 1'b1;

   // Reflected CRC-32, one byte, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
      end
      return c;
   endfunction

endpackage

@@ src/report_seq_crc32_framer.sv @@
// Report framer: sequence nibble insertion and CRC-32 trailer, one byte per cycle when not stalled.
//
// Body bytes stream through at one byte per clock unless held by the trailer or
// by back-pressure. The byte at position seq_offset (position 0 is the
// report ID; seq_offset 0 disables) is replaced by the 4-bit sequence number
// in the high nibble, and the number advances once per report that reached it.
// A reflected CRC-32 seeded from all ones with crc_prefix folded in runs over
// the bytes as sent; after the last body byte the inverted CRC follows as four
// bytes, least significant first, with tuser high and tlast on the fourth.
// The request side is held off while the four trailer bytes go out, so a report
// of N body bytes gives N + 4 response bytes. A report is cut after MAX_REPORT_BYTES - 4
// body bytes. crc_prefix writes take effect from the next report.
module report_seq_crc32_framer #(
   parameter int unsigned MAX_REPORT_BYTES = rscf_pkg::MAX_REPORT_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] data_in
   input  logic                            req_tlast,   // last_in
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] data_out
   output logic                            rsp_tuser,   // [0] is_crc
   output logic                            rsp_tlast,   // last_out
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rscf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int unsigned POS_SPAN = MAX_REPORT_BYTES - 4;
   localparam int unsigned POS_W    = (POS_SPAN > 1) ? $clog2(POS_SPAN) : 1;
   localparam int unsigned LAST_POS = MAX_REPORT_BYTES - 5;

   logic [7:0]       seq_offset_ff, seq_offset_in;
   logic [7:0]       crc_prefix_ff, crc_prefix_in;
   logic [31:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       seq_ff, seq_in;
   logic [2:0]       trail_cnt_ff, trail_cnt_in;
   logic [31:0]      trail_word_ff, trail_word_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_crc_ff, rsp_crc_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             slot_free;
   logic             req_accept;
   logic             csr_write;
   logic             seq_hit;
   logic             is_last;
   logic [7:0]       body_byte;
   logic [31:0]      crc_base;
   logic [31:0]      crc_next;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         rscf_pkg::REG_SEQ_OFFSET: csr_prdata = {24'h0, seq_offset_ff};
         rscf_pkg::REG_CRC_PREFIX: csr_prdata = {24'h0, crc_prefix_ff};
         default:                  csr_prdata = 32'h0;
      endcase
   end

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = slot_free && (trail_cnt_ff == 3'd0);
   assign req_accept = req_tvalid && req_tready;

   assign seq_hit   = (seq_offset_ff != 8'h00) && (8'(pos_ff) == seq_offset_ff);
   assign body_byte = seq_hit ? {seq_ff, 4'h0} : req_tdata;
   assign crc_base  = (pos_ff == '0) ? rscf_pkg::crc_byte(rscf_pkg::CRC_ONES, crc_prefix_ff)
                                     : crc_ff;
   assign crc_next  = rscf_pkg::crc_byte(crc_base, body_byte);
   assign is_last   = req_tlast || (32'(pos_ff) >= LAST_POS);

   always_comb begin
      seq_offset_in = seq_offset_ff;
      crc_prefix_in = crc_prefix_ff;
      crc_in        = crc_ff;
      pos_in        = pos_ff;
      seq_in        = seq_ff;
      trail_cnt_in  = trail_cnt_ff;
      trail_word_in = trail_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_crc_in    = rsp_crc_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_write) begin
         case (csr_paddr[2])
            rscf_pkg::REG_SEQ_OFFSET: seq_offset_in = csr_pwdata[7:0];
            rscf_pkg::REG_CRC_PREFIX: crc_prefix_in = csr_pwdata[7:0];
            default:                  seq_offset_in = seq_offset_ff;
         endcase
      end

      if (slot_free && trail_cnt_ff != 3'd0) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = trail_word_ff[7:0];
         rsp_crc_in    = 1'b1;
         rsp_last_in   = (trail_cnt_ff == 3'd1);
         trail_word_in = {8'h00, trail_word_ff[31:8]};
         trail_cnt_in  = trail_cnt_ff - 3'd1;
      end else if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = body_byte;
         rsp_crc_in   = 1'b0;
         rsp_last_in  = 1'b0;
         crc_in       = crc_next;
         if (seq_hit) begin
            seq_in = seq_ff + 4'd1;
         end
         if (is_last) begin
            pos_in        = '0;
            trail_word_in = ~crc_next;
            trail_cnt_in  = 3'd4;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_offset_ff <= rscf_pkg::OFFSET_RESET;
         crc_prefix_ff <= rscf_pkg::PREFIX_RESET;
         pos_ff        <= '0;
         seq_ff        <= 4'h0;
         trail_cnt_ff  <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seq_offset_ff <= seq_offset_in;
         crc_prefix_ff <= crc_prefix_in;
         pos_ff        <= pos_in;
         seq_ff        <= seq_in;
         trail_cnt_ff  <= trail_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      crc_ff        <= crc_in;
      trail_word_ff <= trail_word_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_crc_ff    <= rsp_crc_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_crc_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ tb/report_seq_crc32_framer_tb.sv @@
// Self-checking testbench for the report framer: sequence nibble and CRC-32 trailer.
module report_seq_crc32_framer_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_AT        = 150;
   localparam int HOLD_CYCLES    = 300;

   localparam logic [rscf_pkg::CSR_ADDR_W-1:0] SEQ_OFFSET_ADDR = {rscf_pkg::REG_SEQ_OFFSET, 2'b00};
   localparam logic [rscf_pkg::CSR_ADDR_W-1:0] CRC_PREFIX_ADDR = {rscf_pkg::REG_CRC_PREFIX, 2'b00};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } body_byte_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_crc;
      logic       last;
   } frame_byte_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata   = '0;
   logic                            req_tlast   = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [7:0]                      rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [rscf_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]                     csr_pwdata  = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   body_byte_type  body_queue[$];
   frame_byte_type frame_bytes_due[$];

   // predictor state and register shadow
   logic [31:0] fcs_run;
   logic [7:0]  body_pos;
   logic [3:0]  seq_num;
   logic [7:0]  seq_slot;
   logic [7:0]  prefix_byte;

   int  mismatches   = 0;
   bit  idle_on      = 1'b1;
   int  req_gap      = 0;
   int  rsp_gap      = 0;
   int  hold_left    = 0;
   int  rsp_seen     = 0;
   int  quiet_cycles = 0;

   report_seq_crc32_framer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic logic [31:0] crc32_fold(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] r;
      r = acc ^ {24'h0, b};
      repeat (8) begin
         if (r[0]) r = (r >> 1) ^ rscf_pkg::CRC_POLY;
         else r = r >> 1;
      end
      return r;
   endfunction

   // one accepted body byte -> one or five frame bytes
   task automatic frame_body_byte(input logic [7:0] din, input logic lin);
      logic [7:0]  dv;
      logic [31:0] fcs;
      logic        ends;
      dv = din;
      ends = lin;
      if (body_pos == 0) fcs_run = crc32_fold(rscf_pkg::CRC_ONES, prefix_byte);
      if (seq_slot != 0 && body_pos == seq_slot) begin
         dv = {seq_num, 4'h0};
         seq_num = seq_num + 4'd1;
      end
      fcs_run = crc32_fold(fcs_run, dv);
      frame_bytes_due.push_back('{data: dv, is_crc: 1'b0, last: 1'b0});
      if (body_pos >= rscf_pkg::MAX_REPORT_BYTES - 5) ends = 1'b1;
      if (!ends) begin
         body_pos = body_pos + 8'd1;
      end else begin
         fcs = ~fcs_run;
         for (int k = 0; k < 4; k++)
            frame_bytes_due.push_back('{data: fcs[8*k +: 8], is_crc: 1'b1, last: (k == 3)});
         body_pos = '0;
         fcs_run = crc32_fold(rscf_pkg::CRC_ONES, prefix_byte);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      body_byte_type nxt;
      logic          fire;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         fire = req_tvalid && req_tready;
         if (fire) frame_body_byte(req_tdata, req_tlast);
         if (!req_tvalid || fire) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
               req_gap = $urandom_range(0, 18);
               req_tvalid <= 1'b0;
            end else if (body_queue.size() != 0) begin
               nxt = body_queue.pop_front();
               req_tdata  <= nxt.data;
               req_tlast  <= nxt.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready control
   always @(posedge clock) begin
      frame_byte_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (frame_bytes_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, got data %h crc %b last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               e = frame_bytes_due.pop_front();
               if (rsp_tdata !== e.data) begin
                  $display("%0t: data_out expected %h got %h", $time, e.data, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== e.is_crc) begin
                  $display("%0t: is_crc expected %b got %b", $time, e.is_crc, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tlast !== e.last) begin
                  $display("%0t: last_out expected %b got %b", $time, e.last, rsp_tlast);
                  mismatches++;
               end
            end
            rsp_seen++;
            if (rsp_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_gap = $urandom_range(0, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [rscf_pkg::CSR_ADDR_W-1:0] addr, input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == SEQ_OFFSET_ADDR) seq_slot = value;
      else prefix_byte = value;
   endtask

   task automatic push_byte(input logic [7:0] d, input logic l);
      body_queue.push_back('{data: d, last: l});
   endtask

   task automatic queue_report(input int len);
      for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (body_queue.size() != 0 || req_tvalid || frame_bytes_due.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      int n;
      int len;
      seq_slot    = rscf_pkg::OFFSET_RESET;
      prefix_byte = rscf_pkg::PREFIX_RESET;
      seq_num     = '0;
      body_pos    = '0;
      fcs_run     = crc32_fold(rscf_pkg::CRC_ONES, prefix_byte);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset config: single-byte and three-byte reports, extremes of data
      @(negedge clock);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b1);
      wait_idle();

      // offset 1, zero prefix; second report ends before the offset
      csr_write(SEQ_OFFSET_ADDR, 8'd1);
      csr_write(CRC_PREFIX_ADDR, 8'h00);
      @(negedge clock);
      push_byte(8'h12, 1'b0);
      push_byte(8'hAA, 1'b0);
      push_byte(8'h55, 1'b1);
      push_byte(8'h34, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      wait_idle();

      // offset never reachable, all-ones prefix
      csr_write(SEQ_OFFSET_ADDR, 8'd255);
      csr_write(CRC_PREFIX_ADDR, 8'hFF);
      @(negedge clock);
      push_byte(8'h7F, 1'b0);
      push_byte(8'hFE, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'hC3, 1'b1);
      wait_idle();

      // prefix changed mid-report: applies from the next report
      csr_write(SEQ_OFFSET_ADDR, 8'd2);
      csr_write(CRC_PREFIX_ADDR, 8'h11);
      @(negedge clock);
      push_byte(8'h31, 1'b0);
      push_byte(8'hE4, 1'b0);
      wait_idle();
      csr_write(CRC_PREFIX_ADDR, 8'h5A);
      @(negedge clock);
      push_byte(8'h9C, 1'b0);
      push_byte(8'h0F, 1'b0);
      push_byte(8'hF0, 1'b1);
      push_byte(8'h31, 1'b0);
      push_byte(8'h66, 1'b1);
      wait_idle();

      // overlong report: cut at the size limit, with the sequence byte on the cut byte
      csr_write(SEQ_OFFSET_ADDR, 8'(rscf_pkg::MAX_REPORT_BYTES - 5));
      csr_write(CRC_PREFIX_ADDR, 8'($urandom_range(0, 255)));
      @(negedge clock);
      for (int i = 0; i < 254; i++) push_byte(8'($urandom_range(0, 255)), i == 253);
      wait_idle();

      // closing reports at full rate
      idle_on = 1'b0;
      case ($urandom_range(0, 5))
         0: csr_write(SEQ_OFFSET_ADDR, 8'd0);
         1: csr_write(SEQ_OFFSET_ADDR, 8'd1);
         2: csr_write(SEQ_OFFSET_ADDR, 8'd255);
         default: csr_write(SEQ_OFFSET_ADDR, 8'($urandom_range(2, 12)));
      endcase
      case ($urandom_range(0, 3))
         0: csr_write(CRC_PREFIX_ADDR, 8'h00);
         1: csr_write(CRC_PREFIX_ADDR, 8'hFF);
         default: csr_write(CRC_PREFIX_ADDR, 8'($urandom_range(0, 255)));
      endcase
      @(negedge clock);
      n = 0;
      while (n < 8) begin
         len = $urandom_range(1, 6);
         queue_report(len);
         n += len;
      end
      wait_idle();

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
